FILE: rtl/core/utf8_display_width_counter_assert.svh
// Assertion macros shared by the display width counter RTL.
`ifndef UTF8_DISPLAY_WIDTH_COUNTER_ASSERT_SVH
`define UTF8_DISPLAY_WIDTH_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define UDW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8 width counter: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define UDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8 width counter: next-cycle check failed");

`endif

FILE: rtl/core/utf8w_pkg.sv
// Shared types, constants and the codepoint width classifier.
`default_nettype none

package utf8w_pkg;

    localparam int WIDTH_W = 14;
    localparam int PEND_W  = 13;
    localparam int CP_W    = 21;
    localparam int CONT_W  = 2;
    localparam int PHASE_W = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_CAP = 14'd8192;
    localparam logic [PEND_W-1:0]  PEND_CAP  = 13'd8191;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ESC   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PARAM = 2'd2;
    localparam logic [PHASE_W-1:0] PH_INTER = 2'd3;

    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_CSI_OPEN = 8'h5B;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [WIDTH_W-1:0] column_width;
        logic               truncated_char;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PEND_W-1:0]  pending;
        logic               cont_busy;
        logic [WIDTH_W-1:0] width;
    } t_step_status;

    function automatic logic [1:0] cp_columns(input logic [CP_W-1:0] cp);
        logic [1:0] cols;
        cols = 2'd1;
        if (cp inside {[21'h00000:21'h0001F], [21'h0007F:21'h0009F]}) begin
            cols = 2'd0;
        end else if (cp inside {[21'h00300:21'h0036F], [21'h01AB0:21'h01AFF],
                                [21'h01DC0:21'h01DFF], [21'h020D0:21'h020FF],
                                [21'h0FE20:21'h0FE2F]}) begin
            cols = 2'd0;
        end else if (cp inside {[21'h01100:21'h0115F], [21'h0AC00:21'h0D7A3],
                                [21'h0F900:21'h0FAFF], [21'h0FE10:21'h0FE19],
                                [21'h0FE30:21'h0FE6F], [21'h0FF00:21'h0FF60],
                                [21'h0FFE0:21'h0FFE6], [21'h20000:21'h2FFFF]}) begin
            cols = 2'd2;
        end else if (cp inside {[21'h02E80:21'h0A4CF]} && cp != 21'h0303F) begin
            cols = 2'd2;
        end
        return cols;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf8w_in_stage.sv
// Input register for incoming byte words.
`default_nettype none

module utf8w_in_stage
    import utf8w_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_tvalid,
    output logic          o_tready,
    input  wire t_in_word i_word,
    input  wire logic     i_advance,
    output logic          o_valid,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_tready = !r_valid || i_advance;
    assign o_valid  = r_valid;
    assign o_word   = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/utf8w_step.sv
// UTF-8 decode, CSI skip and column accumulation state.
`default_nettype none

module utf8w_step
    import utf8w_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_advance,
    input  wire t_in_word i_word,
    output t_result       o_result,
    output t_step_status  o_status
);

    logic [CONT_W-1:0]  r_cont_left;
    logic [CP_W-1:0]    r_cp;
    logic [PHASE_W-1:0] r_phase;
    logic [PEND_W-1:0]  r_pending;
    logic [WIDTH_W-1:0] r_width;

    logic [CONT_W-1:0]  n_cont_left;
    logic [CP_W-1:0]    n_cp;
    logic [PHASE_W-1:0] n_phase;
    logic [PEND_W-1:0]  n_pending;
    logic [WIDTH_W-1:0] n_width;

    logic [7:0]         b;
    logic               is_param;
    logic               is_inter;
    logic               is_final;
    logic               csi_brk;
    logic               normal;
    logic               col_en;
    logic [CP_W-1:0]    col_cp;
    logic [1:0]         cols;
    logic [CONT_W-1:0]  s_cont_left;
    logic [CP_W-1:0]    s_cp;
    logic [PHASE_W-1:0] s_phase;
    logic [PEND_W-1:0]  s_pending;
    logic [PEND_W-1:0]  extra;
    logic [WIDTH_W:0]   sum;
    logic [WIDTH_W-1:0] sat;
    logic [PEND_W-1:0]  pend_inc;

    assign b        = i_word.text_byte;
    assign is_param = b inside {[8'h30:8'h3F]};
    assign is_inter = b inside {[8'h20:8'h2F]};
    assign is_final = b inside {[8'h40:8'h7E]};
    assign pend_inc = (r_pending < PEND_CAP) ? r_pending + 13'd1 : r_pending;

    always_comb begin
        s_cont_left = r_cont_left;
        s_cp        = r_cp;
        s_phase     = r_phase;
        s_pending   = r_pending;
        csi_brk     = 1'b0;
        normal      = 1'b0;
        col_en      = 1'b0;
        col_cp      = {13'd0, b};

        case (r_phase)
            PH_ESC: begin
                if (b == BYTE_CSI_OPEN) begin
                    s_phase   = PH_PARAM;
                    s_pending = 13'd1;
                end else begin
                    csi_brk = 1'b1;
                end
            end
            PH_PARAM: begin
                if (is_param) begin
                    s_pending = pend_inc;
                end else if (is_inter) begin
                    s_phase   = PH_INTER;
                    s_pending = pend_inc;
                end else if (is_final) begin
                    s_phase   = PH_IDLE;
                    s_pending = '0;
                end else begin
                    csi_brk = 1'b1;
                end
            end
            PH_INTER: begin
                if (is_inter) begin
                    s_pending = pend_inc;
                end else if (is_final) begin
                    s_phase   = PH_IDLE;
                    s_pending = '0;
                end else begin
                    csi_brk = 1'b1;
                end
            end
            default: begin
                normal = 1'b1;
            end
        endcase

        if (csi_brk) begin
            s_phase   = PH_IDLE;
            s_pending = '0;
            normal    = 1'b1;
        end

        if (normal) begin
            if (r_cont_left != '0) begin
                s_cp        = {r_cp[CP_W-7:0], b[5:0]};
                s_cont_left = r_cont_left - 2'd1;
                if (r_cont_left == 2'd1) begin
                    col_en = 1'b1;
                    col_cp = {r_cp[CP_W-7:0], b[5:0]};
                end
            end else if (b == BYTE_ESC) begin
                s_phase   = PH_ESC;
                s_pending = '0;
            end else if (b[7] == 1'b0) begin
                col_en = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                s_cp        = {16'd0, b[4:0]};
                s_cont_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                s_cp        = {17'd0, b[3:0]};
                s_cont_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                s_cp        = {18'd0, b[2:0]};
                s_cont_left = 2'd3;
            end else begin
                col_en = 1'b1;
            end
        end
    end

    always_comb begin
        cols = col_en ? cp_columns(col_cp) : 2'd0;
        if (csi_brk) begin
            extra = r_pending;
        end else if (i_word.final_byte && (s_phase == PH_PARAM || s_phase == PH_INTER)) begin
            extra = s_pending;
        end else begin
            extra = '0;
        end
        sum = {1'b0, r_width} + {2'b00, extra} + {13'd0, cols};
        sat = (sum > {1'b0, WIDTH_CAP}) ? WIDTH_CAP : sum[WIDTH_W-1:0];
    end

    always_comb begin
        if (i_word.final_byte) begin
            n_cont_left = '0;
            n_cp        = '0;
            n_phase     = PH_IDLE;
            n_pending   = '0;
            n_width     = '0;
        end else begin
            n_cont_left = s_cont_left;
            n_cp        = s_cp;
            n_phase     = s_phase;
            n_pending   = s_pending;
            n_width     = sat;
        end
    end

    assign o_result.column_width   = sat;
    assign o_result.truncated_char = (s_cont_left != '0);

    assign o_status.phase     = r_phase;
    assign o_status.pending   = r_pending;
    assign o_status.cont_busy = (r_cont_left != '0);
    assign o_status.width     = r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont_left <= '0;
            r_cp        <= '0;
            r_phase     <= PH_IDLE;
            r_pending   <= '0;
            r_width     <= '0;
        end else if (i_advance) begin
            r_cont_left <= n_cont_left;
            r_cp        <= n_cp;
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_width     <= n_width;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/utf8w_out_stage.sv
// Result register toward the output stream.
`default_nettype none

module utf8w_out_stage
    import utf8w_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_tready,
    output logic         o_tvalid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_tvalid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_display_width_counter.sv
// Top level: terminal column width of a UTF-8 byte stream.
//
//  Channel  Dir  Payload                                 Per word
//  s_axis   in   tdata[7:0] text_byte, tlast final_byte  one string byte
//  m_axis   out  tdata[13:0] column_width, tuser[0]      one per string
//                truncated_char
//
//  One byte per cycle sustained while no final byte waits on a stalled m_axis;
//  each byte is held in the input register and the string result appears on
//  m_axis the cycle after the last byte is processed.
//  Reset (i_rst_n low, synchronous) clears all counting state and both valids.
//  A stalled m_axis holds only a final byte and those behind it.
`default_nettype none

module utf8_display_width_counter
    import utf8w_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] text_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [13:0] column_width, [15:14] zero
    output logic [0:0]       m_axis_tuser   // [0] truncated_char
);

    t_in_word     in_word;
    t_in_word     stage_word;
    logic         stage_valid;
    logic         advance;
    logic         load;
    t_result      step_result;
    t_result      out_result;
    t_step_status status;

    assign in_word.text_byte  = s_axis_tdata;
    assign in_word.final_byte = s_axis_tlast;

    assign advance = stage_valid
                  && (!stage_word.final_byte || !m_axis_tvalid || m_axis_tready);
    assign load    = advance && stage_word.final_byte;

    utf8w_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_word    (in_word),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_word    (stage_word)
    );

    utf8w_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (stage_word),
        .o_result  (step_result),
        .o_status  (status)
    );

    utf8w_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (step_result),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {2'b00, out_result.column_width};
    assign m_axis_tuser = out_result.truncated_char;

`include "utf8_display_width_counter_assert.svh"

    `UDW_ASSERT_NEXT(a_final_clears_state, i_clk, i_rst_n, load,
        status.width == '0 && status.phase == PH_IDLE && !status.cont_busy
        && status.pending == '0)
    `UDW_ASSERT_IMP(a_width_capped, i_clk, i_rst_n, 1'b1, status.width <= WIDTH_CAP)
    `UDW_ASSERT_IMP(a_no_pending_outside_csi, i_clk, i_rst_n,
        status.phase == PH_IDLE || status.phase == PH_ESC, status.pending == '0)
    `UDW_ASSERT_IMP(a_char_only_when_idle, i_clk, i_rst_n, status.cont_busy,
        status.phase == PH_IDLE)
    `UDW_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, stage_valid)

endmodule

`default_nettype wire

FILE: tb/utf8_display_width_checker.sv
// Checker: predicts the column width of each string on the input stream and compares results.
`timescale 1ns / 100ps

module utf8_display_width_checker
    import utf8w_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,   // [13:0] column_width, [15:14] zero
    input  wire logic [0:0]  i_m_tuser,   // [0] truncated_char
    output int               o_fail_count,
    output int               o_pending
);

    logic [CONT_W-1:0]  cont_left;
    logic [CP_W-1:0]    cp_acc;
    logic [PHASE_W-1:0] csi_state;
    logic [PEND_W-1:0]  held_cnt;
    logic [WIDTH_W-1:0] col_total;

    t_result expected_widths[$];

    function automatic int glyph_columns(input logic [CP_W-1:0] cp);
        if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return 0;
        if ((cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
            (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
            (cp >= 21'hFE20 && cp <= 21'hFE2F))
            return 0;
        if ((cp >= 21'h1100 && cp <= 21'h115F) ||
            (cp >= 21'h2E80 && cp <= 21'hA4CF && cp != 21'h303F) ||
            (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
            (cp >= 21'hFE10 && cp <= 21'hFE19) || (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
            (cp >= 21'hFF00 && cp <= 21'hFF60) || (cp >= 21'hFFE0 && cp <= 21'hFFE6) ||
            (cp >= 21'h20000 && cp <= 21'h2FFFF))
            return 2;
        return 1;
    endfunction

    task automatic add_columns(input int w);
        int s;
        s = int'(col_total) + w;
        col_total = (s > int'(WIDTH_CAP)) ? WIDTH_CAP : s[WIDTH_W-1:0];
    endtask

    task automatic clear_string();
        cont_left = '0;
        cp_acc    = '0;
        csi_state = PH_IDLE;
        held_cnt  = '0;
        col_total = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (cont_left != 0) begin
            cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) add_columns(glyph_columns(cp_acc));
        end else if (b == BYTE_ESC) begin
            csi_state = PH_ESC;
            held_cnt  = '0;
        end else if (b[7:5] == 3'b110) begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end else begin
            add_columns(glyph_columns({13'd0, b}));
        end
    endtask

    task automatic break_csi(input logic [7:0] b);
        add_columns(int'(held_cnt));
        held_cnt  = '0;
        csi_state = PH_IDLE;
        decode_byte(b);
    endtask

    task automatic count_byte(input logic [7:0] b, input logic last);
        logic is_param;
        logic is_inter;
        logic is_final;
        t_result res;
        is_param = (b >= 8'h30 && b <= 8'h3F);
        is_inter = (b >= 8'h20 && b <= 8'h2F);
        is_final = (b >= 8'h40 && b <= 8'h7E);
        case (csi_state)
            PH_ESC: begin
                if (b == BYTE_CSI_OPEN) begin
                    csi_state = PH_PARAM;
                    held_cnt  = 13'd1;
                end else begin
                    break_csi(b);
                end
            end
            PH_PARAM, PH_INTER: begin
                if ((is_param && csi_state == PH_PARAM) || is_inter) begin
                    if (is_inter) csi_state = PH_INTER;
                    if (held_cnt < PEND_CAP) held_cnt = held_cnt + 1'b1;
                end else if (is_final) begin
                    csi_state = PH_IDLE;
                    held_cnt  = '0;
                end else begin
                    break_csi(b);
                end
            end
            default: decode_byte(b);
        endcase
        if (last) begin
            res.truncated_char = (cont_left != 0);
            if (csi_state == PH_PARAM || csi_state == PH_INTER) add_columns(int'(held_cnt));
            res.column_width = col_total;
            expected_widths.push_back(res);
            clear_string();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_string();
            expected_widths.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_widths.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result width %0d truncated %0d", $time,
                                 i_m_tdata[WIDTH_W-1:0], i_m_tuser[0]);
                end else begin
                    want = expected_widths.pop_front();
                    if (i_m_tdata[WIDTH_W-1:0] !== want.column_width ||
                        i_m_tuser[0] !== want.truncated_char) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: width exp %0d got %0d, truncated exp %0d got %0d",
                                     $time, want.column_width, i_m_tdata[WIDTH_W-1:0],
                                     want.truncated_char, i_m_tuser[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) count_byte(i_s_tdata, i_s_tlast);
        end
        o_pending = expected_widths.size();
    end

endmodule

FILE: tb/testbench.sv
// Testbench top: drives UTF-8 strings into the width counter and reports the verdict.
`timescale 1ns / 100ps

module testbench;
    import utf8w_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {CSI_FULL, CSI_BROKEN, CSI_OPEN} t_csi_shape;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [13:0] column_width, [15:14] zero
    logic [0:0]  m_axis_tuser;   // [0] truncated_char

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;

    logic [7:0] str_q[$];

    utf8_display_width_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    utf8_display_width_checker width_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf8_display_width_counter test failed");
            $finish;
        end
    end

    // hold off once for a long stretch, otherwise stall at random
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_string();
        logic [7:0] b;
        while (str_q.size() > 0) begin
            b = str_q.pop_front();
            send_word(b, str_q.size() == 0);
        end
    endtask

    task automatic send_hex(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) str_q.push_back(v[8*(n-1-i) +: 8]);
        send_string();
    endtask

    task automatic put_char(input logic [CP_W-1:0] cp, input int drop);
        logic [7:0] enc[4];
        int n;
        if (cp < 21'h80) begin
            enc[0] = cp[7:0];
            n = 1;
        end else if (cp < 21'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp < 21'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int i = 0; i < n - drop; i++) str_q.push_back(enc[i]);
    endtask

    function automatic logic [CP_W-1:0] pick_codepoint();
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        case ($urandom_range(0, 18))
            0:  begin lo = 21'h00000; hi = 21'h0001F; end
            1:  begin lo = 21'h0007F; hi = 21'h0009F; end
            2:  begin lo = 21'h00300; hi = 21'h0036F; end
            3:  begin lo = 21'h01AB0; hi = 21'h01AFF; end
            4:  begin lo = 21'h01DC0; hi = 21'h01DFF; end
            5:  begin lo = 21'h020D0; hi = 21'h020FF; end
            6:  begin lo = 21'h0FE20; hi = 21'h0FE2F; end
            7:  begin lo = 21'h01100; hi = 21'h0115F; end
            8:  begin lo = 21'h02E80; hi = 21'h0A4CF; end
            9:  begin lo = 21'h0AC00; hi = 21'h0D7A3; end
            10: begin lo = 21'h0F900; hi = 21'h0FAFF; end
            11: begin lo = 21'h0FE10; hi = 21'h0FE19; end
            12: begin lo = 21'h0FE30; hi = 21'h0FE6F; end
            13: begin lo = 21'h0FF00; hi = 21'h0FF60; end
            14: begin lo = 21'h0FFE0; hi = 21'h0FFE6; end
            15: begin lo = 21'h20000; hi = 21'h2FFFF; end
            16: begin lo = 21'h0303F; hi = 21'h0303F; end
            17: begin lo = 21'h000A0; hi = 21'h010FF; end
            default: begin lo = 21'h30000; hi = 21'h1FFFFF; end
        endcase
        case ($urandom_range(0, 5))
            0: return lo - 1'b1;
            1: return lo;
            2: return hi;
            3: return hi + 1'b1;
            default: return lo + $urandom_range(0, hi - lo);
        endcase
    endfunction

    task automatic put_csi(input t_csi_shape shape);
        int n;
        str_q.push_back(BYTE_ESC);
        if (shape == CSI_FULL || $urandom_range(0, 3) != 0) str_q.push_back(BYTE_CSI_OPEN);
        n = $urandom_range(0, 3);
        repeat (n) str_q.push_back(8'($urandom_range(8'h30, 8'h3F)));
        n = $urandom_range(0, 2);
        repeat (n) str_q.push_back(8'($urandom_range(8'h20, 8'h2F)));
        case (shape)
            CSI_FULL:   str_q.push_back(8'($urandom_range(8'h40, 8'h7E)));
            CSI_BROKEN: begin
                case ($urandom_range(0, 2))
                    0: str_q.push_back(8'($urandom_range(8'h00, 8'h1F)));
                    1: str_q.push_back(8'($urandom_range(8'h7F, 8'hFF)));
                    default: str_q.push_back(BYTE_ESC);
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic build_random_string();
        int n_tok;
        int r;
        int len;
        logic [6:0] small_cp;
        n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        repeat (n_tok) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (r < 65) begin
                put_char(pick_codepoint(), 0);
            end else if (r < 80) begin
                put_csi(CSI_FULL);
            end else if (r < 85) begin
                small_cp = 7'($urandom_range(0, 127));
                str_q.push_back({7'b1100000, small_cp[6]});
                str_q.push_back({2'b10, small_cp[5:0]});
            end else if (r < 93) begin
                str_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                put_csi(CSI_BROKEN);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            len = $urandom_range(2, 4);
            case (len)
                2: put_char(21'($urandom_range(21'h80, 21'h7FF)), $urandom_range(1, 1));
                3: put_char(21'($urandom_range(21'h800, 21'hFFFF)), $urandom_range(1, 2));
                default: put_char(21'($urandom_range(21'h10000, 21'h1FFFFF)),
                                  $urandom_range(1, 3));
            endcase
        end else if (r < 18) begin
            put_csi(CSI_OPEN);
        end
    endtask

    initial begin
        int send_pcts[3];
        int recv_pcts[3];
        int phase_bytes;
        int phase_strings;
        send_pcts = '{32, 58, 0};
        recv_pcts = '{58, 32, 0};
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = send_pcts[0];
        recv_idle_pct = recv_pcts[0];
        send_hex(64'h00, 1);
        send_hex(64'hFF, 1);
        send_hex(64'h41, 1);
        send_hex(64'h7E7F, 2);
        send_hex(64'hC3A9CC80, 4);
        send_hex(64'hE4B8ADEAB080, 6);
        send_hex(64'hE380BFEFBDA0, 6);
        send_hex(64'hF0A08080F0AFBFBF, 8);
        send_hex(64'hF7BFBFBF, 4);
        send_hex(64'hE4B8, 2);
        send_hex(64'h1B5B33316D41, 6);
        send_hex(64'h1B5B312071, 5);
        send_hex(64'h1B5B310A78, 5);
        send_hex(64'h1B41, 2);
        send_hex(64'h1B5B1B5B6D, 5);
        send_hex(64'h1B5B32, 3);
        send_hex(64'h1B, 1);
        send_hex(64'hC09B5B6D, 4);
        send_hex(64'h80BFF8, 3);

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = send_pcts[p];
            recv_idle_pct = recv_pcts[p];
            if (p == 2) hold_go = 1'b1;
            phase_bytes   = 0;
            phase_strings = 0;
            while (phase_bytes < 185 || phase_strings < 16) begin
                build_random_string();
                phase_bytes += str_q.size();
                phase_strings++;
                send_string();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("utf8_display_width_counter test passed");
        else
            $display("utf8_display_width_counter test failed");
        $finish;
    end

endmodule
